/* rtl/dcpt_pkg.sv */
// Package for the disc pair collision time pipeline.
// Holds the fixed datapath widths and parameter defaults; depends on nothing.
package dcpt_pkg;

  // Default number of fraction bits of the reported time.
  localparam int unsigned TIME_FRACTION_BITS_DEF = 16;

  // Input field widths.
  localparam int unsigned POS_W  = 32;
  localparam int unsigned RAD_W  = 25;

  // Relative position and velocity, and their products.
  localparam int unsigned DIFF_W = 33;
  localparam int unsigned PROD_W = 66;

  // Dot and cross products, and their magnitudes.
  localparam int unsigned C1_W   = 67;
  localparam int unsigned MAG_W  = 66;
  localparam int unsigned CM_W   = 64;

  // Radius sum and its square.
  localparam int unsigned RSUM_W = 26;
  localparam int unsigned R2_W   = 52;

  // Chunking of c2 * R^2 into partial products.
  localparam int unsigned C2_CHUNK = 22;
  localparam int unsigned C2_PARTS = 3;
  localparam int unsigned R2_CHUNK = 26;
  localparam int unsigned R2_PARTS = 2;
  localparam int unsigned PP_W     = C2_CHUNK + R2_CHUNK;

  // Squared cross product, discriminant and its root.
  localparam int unsigned CROSS_W = 128;
  localparam int unsigned D_W     = 118;
  localparam int unsigned ROOT_W  = 59;

  // Result time width.
  localparam int unsigned TIME_W  = 32;

endpackage

/* rtl/dcpt_isqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Depends on dcpt_pkg for default widths.
module dcpt_isqrt import dcpt_pkg::*; #(
  parameter int unsigned IN_W  = D_W,
  parameter int unsigned OUT_W = ROOT_W,
  parameter int unsigned SB_W  = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   rad_i,
  input  logic [SB_W-1:0]   sb_i,
  output logic              valid_o,
  output logic [OUT_W-1:0]  root_o,
  output logic [SB_W-1:0]   sb_o
);

  localparam int unsigned RW = OUT_W + 2;

  logic             valid_q [1:OUT_W];
  logic [RW-1:0]    rem_q   [1:OUT_W];
  logic [RW-1:0]    rem_d   [1:OUT_W];
  logic [OUT_W-1:0] root_q  [1:OUT_W];
  logic [OUT_W-1:0] root_d  [1:OUT_W];
  logic [IN_W-1:0]  rest_q  [1:OUT_W];
  logic [IN_W-1:0]  rest_d  [1:OUT_W];
  logic [SB_W-1:0]  sb_q    [1:OUT_W];
  logic [SB_W-1:0]  sb_d    [1:OUT_W];

  // Each stage brings down two radicand bits and tries to set one root bit.
  always_comb begin
    logic [RW-1:0]    rem_s;
    logic [RW-1:0]    cur;
    logic [RW-1:0]    trial;
    logic [OUT_W-1:0] root_s;
    logic [IN_W-1:0]  rest_s;
    logic [SB_W-1:0]  sb_s;
    for (int k = 0; k < OUT_W; k++) begin
      if (k == 0) begin
        rem_s  = '0;
        root_s = '0;
        rest_s = rad_i;
        sb_s   = sb_i;
      end else begin
        rem_s  = rem_q[k];
        root_s = root_q[k];
        rest_s = rest_q[k];
        sb_s   = sb_q[k];
      end
      cur   = {rem_s[RW-3:0], rest_s[IN_W-1 -: 2]};
      trial = {root_s, 2'b01};
      if (cur >= trial) begin
        rem_d[k+1]  = cur - trial;
        root_d[k+1] = {root_s[OUT_W-2:0], 1'b1};
      end else begin
        rem_d[k+1]  = cur;
        root_d[k+1] = {root_s[OUT_W-2:0], 1'b0};
      end
      rest_d[k+1] = {rest_s[IN_W-3:0], 2'b00};
      sb_d[k+1]   = sb_s;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= OUT_W; k++) valid_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 1; k <= OUT_W; k++) begin
        if (k == 1) valid_q[k] <= valid_i;
        else        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 1; k <= OUT_W; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rest_q[k] <= rest_d[k];
        sb_q[k]   <= sb_d[k];
      end
    end
  end

  assign valid_o = valid_q[OUT_W];
  assign root_o  = root_q[OUT_W];
  assign sb_o    = sb_q[OUT_W];

endmodule

/* rtl/dcpt_div.sv */
// Pipelined restoring divider producing a fixed number of quotient bits,
// one per register stage. Depends on dcpt_pkg for default widths.
module dcpt_div import dcpt_pkg::*; #(
  parameter int unsigned N_W   = MAG_W + TIME_FRACTION_BITS_DEF,
  parameter int unsigned DEN_W = MAG_W,
  parameter int unsigned Q_W   = TIME_W,
  parameter int unsigned SB_W  = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [N_W-1:0]    num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SB_W-1:0]   sb_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quot_o,
  output logic [SB_W-1:0]   sb_o
);

  logic             valid_q [1:Q_W];
  logic [DEN_W-1:0] rem_q   [1:Q_W];
  logic [DEN_W-1:0] rem_d   [1:Q_W];
  logic [Q_W-1:0]   low_q   [1:Q_W];
  logic [Q_W-1:0]   low_d   [1:Q_W];
  logic [Q_W-1:0]   quot_q  [1:Q_W];
  logic [Q_W-1:0]   quot_d  [1:Q_W];
  logic [DEN_W-1:0] den_q   [1:Q_W];
  logic [DEN_W-1:0] den_d   [1:Q_W];
  logic [SB_W-1:0]  sb_q    [1:Q_W];
  logic [SB_W-1:0]  sb_d    [1:Q_W];

  // The upper numerator bits lie below the divisor when the quotient fits,
  // so each stage shifts in one low bit and subtracts once.
  always_comb begin
    logic [DEN_W-1:0] rem_s;
    logic [DEN_W:0]   cur;
    logic [Q_W-1:0]   low_s;
    logic [Q_W-1:0]   quot_s;
    logic [DEN_W-1:0] den_s;
    logic [SB_W-1:0]  sb_s;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        rem_s  = DEN_W'(num_i[N_W-1:Q_W]);
        low_s  = num_i[Q_W-1:0];
        quot_s = '0;
        den_s  = den_i;
        sb_s   = sb_i;
      end else begin
        rem_s  = rem_q[k];
        low_s  = low_q[k];
        quot_s = quot_q[k];
        den_s  = den_q[k];
        sb_s   = sb_q[k];
      end
      cur = {rem_s, low_s[Q_W-1]};
      if (cur >= {1'b0, den_s}) begin
        rem_d[k+1]  = DEN_W'(cur - {1'b0, den_s});
        quot_d[k+1] = {quot_s[Q_W-2:0], 1'b1};
      end else begin
        rem_d[k+1]  = cur[DEN_W-1:0];
        quot_d[k+1] = {quot_s[Q_W-2:0], 1'b0};
      end
      low_d[k+1] = {low_s[Q_W-2:0], 1'b0};
      den_d[k+1] = den_s;
      sb_d[k+1]  = sb_s;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= Q_W; k++) valid_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 1; k <= Q_W; k++) begin
        if (k == 1) valid_q[k] <= valid_i;
        else        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 1; k <= Q_W; k++) begin
        rem_q[k]  <= rem_d[k];
        low_q[k]  <= low_d[k];
        quot_q[k] <= quot_d[k];
        den_q[k]  <= den_d[k];
        sb_q[k]   <= sb_d[k];
      end
    end
  end

  assign valid_o = valid_q[Q_W];
  assign quot_o  = quot_q[Q_W];
  assign sb_o    = sb_q[Q_W];

endmodule

/* rtl/disc_pair_collision_time.sv */
// Predicts when two moving hard discs first touch. Every cycle in which the
// output is not stalled the block can take one request holding both discs,
// and it delivers one result per request, in order. The pipeline is 100
// register stages long: six stages for the differences, products and
// discriminant, 59 for the square root (one root bit each), two for the
// numerator and range check, 32 for the divider (one time bit each) and the
// output register. A stalled output holds the whole pipeline.
// Depends on dcpt_pkg, dcpt_isqrt and dcpt_div.
module disc_pair_collision_time import dcpt_pkg::*; #(
  parameter int unsigned TIME_FRACTION_BITS = TIME_FRACTION_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [POS_W-1:0] first_x_i,
  input  logic signed [POS_W-1:0] first_y_i,
  input  logic signed [POS_W-1:0] first_vx_i,
  input  logic signed [POS_W-1:0] first_vy_i,
  input  logic [RAD_W-1:0]        first_radius_i,
  input  logic signed [POS_W-1:0] second_x_i,
  input  logic signed [POS_W-1:0] second_y_i,
  input  logic signed [POS_W-1:0] second_vx_i,
  input  logic signed [POS_W-1:0] second_vy_i,
  input  logic [RAD_W-1:0]        second_radius_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    will_hit_o,
  output logic [TIME_W-1:0]       hit_time_o,
  output logic                    time_saturated_o
);

  localparam int unsigned N_W   = MAG_W + TIME_FRACTION_BITS;
  localparam int unsigned CMP_W = (N_W > MAG_W + TIME_W) ? N_W : MAG_W + TIME_W;
  localparam int unsigned SQ_SB = 2 * MAG_W + 1;

  logic en;

  // Stage 1: relative position, velocity and radius sum.
  logic                     v1_q;
  logic signed [DIFF_W-1:0] dpx_q, dpy_q, dvx_q, dvy_q;
  logic [RSUM_W-1:0]        rsum_q;

  // Stage 2: products.
  logic                     v2_q;
  logic signed [PROD_W-1:0] pxx_q, pyy_q, vxx_q, vyy_q, xy_q, yx_q;
  logic [R2_W-1:0]          r2_q;

  // Stage 3: dot products, cross product magnitude.
  logic                     v3_q;
  logic [MAG_W-1:0]         c1m_d, c1m_q, c2_d, c2_q;
  logic [CM_W-1:0]          cm_d, cm_q;
  logic                     miss3_d, miss3_q;
  logic [R2_W-1:0]          r2b_q;
  logic signed [C1_W-1:0]   c1, cr;
  logic [C1_W-1:0]          c1neg, crmag;

  // Stage 4: partial products.
  logic                     v4_q;
  logic [2*CM_W/2-1:0]      hh_q, hl_q, ll_q;
  logic [PP_W-1:0]          pp_d [C2_PARTS][R2_PARTS];
  logic [PP_W-1:0]          pp_q [C2_PARTS][R2_PARTS];
  logic [MAG_W-1:0]         c1m4_q, c24_q;
  logic                     miss4_q;

  // Stage 5: squared cross product and c2 * R^2.
  logic                     v5_q;
  logic [CROSS_W-1:0]       cross2_q;
  logic [D_W-1:0]           c2r2_d, c2r2_q;
  logic [MAG_W-1:0]         c1m5_q, c25_q;
  logic                     miss5_q;

  // Stage 6: discriminant.
  logic                     v6_q;
  logic [D_W-1:0]           d_q;
  logic [MAG_W-1:0]         c1m6_q, c26_q;
  logic                     miss6_q;

  // Square root outputs.
  logic                     sq_valid;
  logic [ROOT_W-1:0]        sq_root;
  logic [SQ_SB-1:0]         sq_sb;
  logic [MAG_W-1:0]         sq_c1m, sq_c2, root_ext;
  logic                     sq_miss;

  // Stage 7: numerator.
  logic                     v7_q;
  logic [MAG_W-1:0]         n_q, c27_q;
  logic                     ovl7_q, miss7_q;

  // Stage 8: range check.
  logic                     v8_q;
  logic [N_W-1:0]           num_d, num_q;
  logic [MAG_W-1:0]         c28_q;
  logic                     sat8_q, ovl8_q, miss8_q;

  // Divider outputs.
  logic                     dv_valid;
  logic [TIME_W-1:0]        dv_quot;
  logic [2:0]               dv_sb;

  // Output register.
  logic                     out_valid_q;
  logic                     will_hit_d, will_hit_q, sat_d, sat_q;
  logic [TIME_W-1:0]        hit_time_d, hit_time_q;

  // The pipeline moves whenever the output register is free or being taken.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 3 arithmetic: sums, magnitudes and the early miss tests.
  always_comb begin
    c1      = C1_W'(pxx_q) + C1_W'(pyy_q);
    c1neg   = -c1;
    c1m_d   = c1neg[MAG_W-1:0];
    c2_d    = MAG_W'(vxx_q[PROD_W-2:0]) + MAG_W'(vyy_q[PROD_W-2:0]);
    cr      = C1_W'(xy_q) - C1_W'(yx_q);
    crmag   = cr[C1_W-1] ? -cr : cr;
    cm_d    = crmag[CM_W-1:0];
    miss3_d = !c1[C1_W-1] || (c2_d == '0) || (|crmag[C1_W-1:CM_W]);
  end

  // Stage 4 arithmetic: c2 * R^2 in chunks.
  always_comb begin
    for (int i = 0; i < C2_PARTS; i++) begin
      for (int j = 0; j < R2_PARTS; j++) begin
        pp_d[i][j] = PP_W'(c2_q[C2_CHUNK*i +: C2_CHUNK]) * PP_W'(r2b_q[R2_CHUNK*j +: R2_CHUNK]);
      end
    end
  end

  // Stage 5 arithmetic: add the chunked partial products.
  always_comb begin
    c2r2_d = '0;
    for (int i = 0; i < C2_PARTS; i++) begin
      for (int j = 0; j < R2_PARTS; j++) begin
        c2r2_d = c2r2_d + (D_W'(pp_q[i][j]) << (C2_CHUNK*i + R2_CHUNK*j));
      end
    end
  end

  // Sideband out of the square root.
  assign sq_c1m   = sq_sb[SQ_SB-1 -: MAG_W];
  assign sq_c2    = sq_sb[MAG_W:1];
  assign sq_miss  = sq_sb[0];
  assign root_ext = MAG_W'(sq_root);

  // Stage 8 arithmetic: scaled numerator.
  assign num_d = N_W'(n_q) << TIME_FRACTION_BITS;

  // Valid bits of the local stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= sq_valid;
      v8_q        <= v7_q;
      out_valid_q <= dv_valid;
    end
  end

  // Payload of the local stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dpx_q    <= {second_x_i[POS_W-1], second_x_i} - {first_x_i[POS_W-1], first_x_i};
      dpy_q    <= {second_y_i[POS_W-1], second_y_i} - {first_y_i[POS_W-1], first_y_i};
      dvx_q    <= {second_vx_i[POS_W-1], second_vx_i} - {first_vx_i[POS_W-1], first_vx_i};
      dvy_q    <= {second_vy_i[POS_W-1], second_vy_i} - {first_vy_i[POS_W-1], first_vy_i};
      rsum_q   <= RSUM_W'(first_radius_i) + RSUM_W'(second_radius_i);

      pxx_q    <= dvx_q * dpx_q;
      pyy_q    <= dvy_q * dpy_q;
      vxx_q    <= dvx_q * dvx_q;
      vyy_q    <= dvy_q * dvy_q;
      xy_q     <= dvx_q * dpy_q;
      yx_q     <= dvy_q * dpx_q;
      r2_q     <= R2_W'(rsum_q) * R2_W'(rsum_q);

      c1m_q    <= c1m_d;
      c2_q     <= c2_d;
      cm_q     <= cm_d;
      miss3_q  <= miss3_d;
      r2b_q    <= r2_q;

      hh_q     <= CM_W'(cm_q[CM_W-1:CM_W/2]) * CM_W'(cm_q[CM_W-1:CM_W/2]);
      hl_q     <= CM_W'(cm_q[CM_W-1:CM_W/2]) * CM_W'(cm_q[CM_W/2-1:0]);
      ll_q     <= CM_W'(cm_q[CM_W/2-1:0]) * CM_W'(cm_q[CM_W/2-1:0]);
      pp_q     <= pp_d;
      c1m4_q   <= c1m_q;
      c24_q    <= c2_q;
      miss4_q  <= miss3_q;

      cross2_q <= (CROSS_W'(hh_q) << CM_W) + (CROSS_W'(hl_q) << (CM_W/2 + 1))
                  + CROSS_W'(ll_q);
      c2r2_q   <= c2r2_d;
      c1m5_q   <= c1m4_q;
      c25_q    <= c24_q;
      miss5_q  <= miss4_q;

      d_q      <= c2r2_q - cross2_q[D_W-1:0];
      c1m6_q   <= c1m5_q;
      c26_q    <= c25_q;
      miss6_q  <= miss5_q || (cross2_q >= CROSS_W'(c2r2_q));

      n_q      <= sq_c1m - root_ext;
      ovl7_q   <= sq_c1m < root_ext;
      c27_q    <= sq_c2;
      miss7_q  <= sq_miss;

      num_q    <= num_d;
      sat8_q   <= CMP_W'(num_d) >= (CMP_W'(c27_q) << TIME_W);
      c28_q    <= c27_q;
      ovl8_q   <= ovl7_q;
      miss8_q  <= miss7_q;

      will_hit_q <= will_hit_d;
      hit_time_q <= hit_time_d;
      sat_q      <= sat_d;
    end
  end

  // Square root of the discriminant.
  dcpt_isqrt #(
    .IN_W  (D_W),
    .OUT_W (ROOT_W),
    .SB_W  (SQ_SB)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .rad_i   (d_q),
    .sb_i    ({c1m6_q, c26_q, miss6_q}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  // Time = scaled numerator over c2.
  dcpt_div #(
    .N_W   (N_W),
    .DEN_W (MAG_W),
    .Q_W   (TIME_W),
    .SB_W  (3)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8_q),
    .num_i   (num_q),
    .den_i   (c28_q),
    .sb_i    ({miss8_q, ovl8_q, sat8_q}),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .sb_o    (dv_sb)
  );

  // Result selection: miss, past contact, clamped time or the quotient.
  always_comb begin
    if (dv_sb[2]) begin
      will_hit_d = 1'b0;
      hit_time_d = '0;
      sat_d      = 1'b0;
    end else if (dv_sb[1]) begin
      will_hit_d = 1'b1;
      hit_time_d = '0;
      sat_d      = 1'b1;
    end else if (dv_sb[0]) begin
      will_hit_d = 1'b1;
      hit_time_d = '1;
      sat_d      = 1'b1;
    end else begin
      will_hit_d = 1'b1;
      hit_time_d = dv_quot;
      sat_d      = 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign will_hit_o       = will_hit_q;
  assign hit_time_o       = hit_time_q;
  assign time_saturated_o = sat_q;

  // A miss carries neither a time nor a clamp flag.
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !will_hit_o) |-> (hit_time_o == '0 && !time_saturated_o))
    else $error("miss result carries a time or clamp flag");

  // A clamped time is either the past-contact zero or the full-scale value.
  a_sat_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && time_saturated_o) |->
      (will_hit_o && (hit_time_o == '0 || hit_time_o == '1)))
    else $error("clamped result has an unexpected time");

  // The pipeline freezes while a result waits.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(v8_q) && $stable(v1_q)))
    else $error("pipeline moved during an output stall");

endmodule

/* test/tb_disc_pair_collision_time.sv */
// Self-checking testbench for disc_pair_collision_time.
// Drives disc pair requests, predicts each result in wide integer arithmetic
// and compares it with the block's output; depends on dcpt_pkg and the RTL.
module tb_disc_pair_collision_time import dcpt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TFB        = TIME_FRACTION_BITS_DEF;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned N_RANDOM   = 800;

  typedef struct {
    logic signed [POS_W-1:0] ax, ay, avx, avy, bx, by, bvx, bvy;
    logic [RAD_W-1:0]        ar, br;
    bit                      drain_first;
  } disc_pair_t;

  typedef struct {
    logic              hit;
    logic [TIME_W-1:0] t;
    logic              sat;
  } contact_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, will_hit_o, time_saturated_o;
  logic [TIME_W-1:0] hit_time_o;
  disc_pair_t cur = '{default: '0};

  disc_pair_t pending_q[$];
  contact_t   contact_q[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  bit in_taken = 1'b0, out_taken = 1'b0;
  int unsigned send_gap = 0, recv_gap = 0, hold_left = 0;
  bit long_hold_done = 1'b0;
  bit calm = 1'b0;
  int unsigned idle_cycles = 0;

  disc_pair_collision_time dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .first_x_i(cur.ax), .first_y_i(cur.ay), .first_vx_i(cur.avx), .first_vy_i(cur.avy),
    .first_radius_i(cur.ar),
    .second_x_i(cur.bx), .second_y_i(cur.by), .second_vx_i(cur.bvx),
    .second_vy_i(cur.bvy), .second_radius_i(cur.br),
    .out_valid_o, .out_ready_i, .will_hit_o, .hit_time_o, .time_saturated_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Integer square root, floor, of a value below 2^128.
  function automatic logic [255:0] floor_root(logic [255:0] v);
    logic [255:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (256'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // Expected contact time of one disc pair, exact integer arithmetic.
  function automatic contact_t contact_of(disc_pair_t p);
    logic signed [255:0] dpx, dpy, dvx, dvy, c1, c2, cr;
    logic [255:0] rsum, c2r2, cross2, d, s, m, q;
    contact_t res;
    res = '{hit: 1'b0, t: '0, sat: 1'b0};
    dpx = 256'(p.bx) - 256'(p.ax);
    dpy = 256'(p.by) - 256'(p.ay);
    dvx = 256'(p.bvx) - 256'(p.avx);
    dvy = 256'(p.bvy) - 256'(p.avy);
    rsum = 256'(p.ar) + 256'(p.br);
    c1 = dvx * dpx + dvy * dpy;
    if (c1 >= 0) return res;
    c2 = dvx * dvx + dvy * dvy;
    if (c2 == 0) return res;
    cr = dvx * dpy - dvy * dpx;
    if (cr < 0) cr = -cr;
    if (cr >= (256'sd1 <<< 64)) return res;
    cross2 = cr * cr;
    c2r2 = c2 * rsum * rsum;
    if (cross2 >= c2r2) return res;
    d = c2r2 - cross2;
    s = floor_root(d);
    res.hit = 1'b1;
    m = -c1;
    if (m < s) begin
      res.sat = 1'b1;
      return res;
    end
    q = ((m - s) << TFB) / c2;
    if (q > 256'hFFFF_FFFF) begin
      res.t = '1;
      res.sat = 1'b1;
    end else begin
      res.t = q[TIME_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [POS_W-1:0] rnd32();
    return POS_W'($urandom);
  endfunction

  // Value with a random magnitude scale, so small and large numbers both occur.
  function automatic logic signed [POS_W-1:0] rnd_scaled();
    return rnd32() >>> $urandom_range(0, 31);
  endfunction

  function automatic logic [RAD_W-1:0] rnd_radius();
    case ($urandom_range(0, 5))
      0: return RAD_W'($urandom);
      1: return RAD_W'(1 << 24);
      default: return RAD_W'($urandom_range(0, 1 << 24));
    endcase
  endfunction

  // Pair set on a closing course: second disc offset from the first and moving back.
  function automatic disc_pair_t closing_pair();
    disc_pair_t p;
    int sh;
    sh = $urandom_range(0, 8);
    p.ax = rnd_scaled();  p.ay = rnd_scaled();
    p.avx = rnd_scaled(); p.avy = rnd_scaled();
    p.bx = p.ax + (rnd32() >>> $urandom_range(4, 30));
    p.by = p.ay + (rnd32() >>> $urandom_range(4, 30));
    p.bvx = p.avx - ((p.bx - p.ax) >>> sh) + (rnd32() >>> $urandom_range(8, 31));
    p.bvy = p.avy - ((p.by - p.ay) >>> sh) + (rnd32() >>> $urandom_range(8, 31));
    p.ar = rnd_radius();
    p.br = rnd_radius();
    p.drain_first = 1'b0;
    return p;
  endfunction

  function automatic disc_pair_t make_pair(int x1, int y1, int vx1, int vy1, int r1,
                                           int x2, int y2, int vx2, int vy2, int r2);
    disc_pair_t p;
    p = '{ax: x1, ay: y1, avx: vx1, avy: vy1, ar: RAD_W'(r1),
          bx: x2, by: y2, bvx: vx2, bvy: vy2, br: RAD_W'(r2), drain_first: 1'b0};
    return p;
  endfunction

  // Stimulus: directed cases first, then random pairs.
  initial begin
    disc_pair_t p;
    int one;
    one = 1 << 24;
    // Extremes of every field.
    pending_q.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_pair(-1, -1, -1, -1, '1, -1, -1, -1, -1, '1));
    pending_q.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
      32'h7fff_ffff, one, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, one));
    pending_q.push_back(make_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
      32'h8000_0000, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0));
    // Head-on approach, a clean hit.
    pending_q.push_back(make_pair(0, 0, one, 0, one / 2, 8 * one, 0, -one, 0, one / 2));
    // Moving apart, no hit.
    pending_q.push_back(make_pair(0, 0, -one, 0, one, 8 * one, 0, one, 0, one));
    // Zero relative velocity.
    pending_q.push_back(make_pair(0, 0, one, one, one, 3 * one, 0, one, one, one));
    // Closing but passing wide of each other.
    pending_q.push_back(make_pair(0, 0, one, 0, 100, 8 * one, 5 * one, -one, 0, 100));
    // Already overlapping while closing.
    pending_q.push_back(make_pair(0, 0, one, 0, one, one / 2, 0, 0, 0, one));
    // Very slow approach from far: time clamps.
    pending_q.push_back(make_pair(-(100 * one), 0, 1, 0, 10, 100 * one, 0, -1, 0, 10));
    // Radii beyond 1.0 and at 1.0.
    pending_q.push_back(make_pair(0, 0, 0, 0, '1, 5 * one, one, -one, 0, '1));
    pending_q.push_back(make_pair(0, 0, 0, 0, one, 5 * one, one, -one, 0, one));
    // Grazing contact exactly on the sum of radii.
    pending_q.push_back(make_pair(0, 0, 0, 0, one, 6 * one, 2 * one, -one, 0, one));
    // Diagonal approach.
    pending_q.push_back(make_pair(0, 0, one, one, one / 4, 4 * one, 4 * one, -one, -one,
      one / 4));
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        p = closing_pair();
      end else begin
        p = '{ax: rnd32(), ay: rnd32(), avx: rnd32(), avy: rnd32(),
              ar: RAD_W'($urandom), bx: rnd32(), by: rnd32(), bvx: rnd32(),
              bvy: rnd32(), br: RAD_W'($urandom), drain_first: 1'b0};
      end
      p.drain_first = (i == N_RANDOM / 2);
      pending_q.push_back(p);
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && !in_valid_i && contact_q.size() == 0);
    repeat (150) @(posedge clk_i);
    if (mismatches == 0 && contact_q.size() == 0) begin
      $display("[disc_pair_collision_time] OK");
    end else begin
      $display("[disc_pair_collision_time] ERROR");
    end
    $finish;
  end

  // Request acceptance: record the expected result of each accepted pair.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      contact_q.push_back(contact_of(cur));
      in_taken <= 1'b1;
    end
  end

  // Driver: offers pending pairs at the falling edge with random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      in_valid_i <= 1'b1;
    end else begin
      in_taken <= 1'b0;
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (pending_q[0].drain_first && contact_q.size() != 0) begin
        in_valid_i <= 1'b0;
      end else begin
        cur <= pending_q.pop_front();
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 99) == 0) calm <= ~calm;
        send_gap <= calm ? 0 : $urandom_range(0, 8);
      end
    end
  end

  // Monitor: compare each delivered result with the oldest expectation.
  always @(posedge clk_i) begin
    contact_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      out_taken <= 1'b1;
      results_seen <= results_seen + 1;
      if (contact_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = contact_q.pop_front();
        if (e.hit !== will_hit_o || e.t !== hit_time_o || e.sat !== time_saturated_o)
        begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch at %0t: expected hit=%0b time=%h sat=%0b, got %0b %h %0b",
              $realtime, e.hit, e.t, e.sat, will_hit_o, hit_time_o, time_saturated_o);
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold so the pipeline fills.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && results_seen >= 300) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready_i <= 1'b0;
    end else if (out_taken || !out_ready_i) begin
      out_taken <= 1'b0;
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_gap <= calm ? 0 : $urandom_range(0, 8);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[disc_pair_collision_time] ERROR");
        $finish;
      end
    end
  end
endmodule

/* sim.f */
rtl/dcpt_pkg.sv
rtl/dcpt_isqrt.sv
rtl/dcpt_div.sv
rtl/disc_pair_collision_time.sv
test/tb_disc_pair_collision_time.sv
